FILE: hw/rtl/dqds_pkg.sv
// Package: shared types, widths, codes and reset values for the input qualifier
`timescale 1ns / 1ps

package dqds_pkg;

	// fixed field widths
	localparam int unsigned STATUS_W     = 16;
	localparam int unsigned FN_W         = 4;
	localparam int unsigned DEMAND_W     = 14;
	localparam int unsigned TABLE_WORD_W = 56;
	localparam int unsigned CFG_DATA_W   = 64;
	localparam int unsigned CFG_INDEX_W  = 3;
	localparam int unsigned DEMAND_IDX_W = 3;

	// default number of inputs in use
	localparam int unsigned NUM_INPUTS_DEF = 16;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_ENABLE_MASK   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_POLARITY_MASK = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_FUNCTION_MAP  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_DEMAND_LOW    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_DEMAND_HIGH   = 3'd4;

	// function codes
	localparam logic [FN_W-1:0] FN_MOTOR_ENABLE = 4'd0;
	localparam logic [FN_W-1:0] FN_DIRECTION    = 4'd2;
	localparam logic [FN_W-1:0] FN_LAST_COMMAND = 4'd4;
	localparam logic [FN_W-1:0] FN_DEMAND_FIRST = 4'd5;
	localparam logic [FN_W-1:0] FN_DEMAND_LAST  = 4'd8;

	localparam logic [DEMAND_W-1:0] DEMAND_MAX = 14'd10000;

	// reset values
	localparam logic [STATUS_W-1:0]     ENABLE_RST   = 16'hFFFF;
	localparam logic [STATUS_W-1:0]     POLARITY_RST = 16'h0000;
	localparam logic [CFG_DATA_W-1:0]   FNMAP_RST    = 64'hFFFF_FFFF_FFFF_7652;
	localparam logic [TABLE_WORD_W-1:0] DEMAND_LOW_RST  =
		{14'd6000, 14'd5000, 14'd4000, 14'd0};
	localparam logic [TABLE_WORD_W-1:0] DEMAND_HIGH_RST =
		{14'd10000, 14'd9000, 14'd8000, 14'd7000};

	// configuration as seen by the datapath
	typedef struct packed {
		logic [STATUS_W-1:0]     enable_mask;
		logic [STATUS_W-1:0]     polarity_mask;
		logic [CFG_DATA_W-1:0]   function_map;
		logic [TABLE_WORD_W-1:0] demand_low;
		logic [TABLE_WORD_W-1:0] demand_high;
	} cfg_t;

	// one result item
	typedef struct packed {
		logic [STATUS_W-1:0] qualified_status;
		logic [STATUS_W-1:0] command_values;
		logic                motor_enabled;
		logic                direction_inverted;
		logic [DEMAND_W-1:0] demand_percent;
	} result_t;

endpackage

FILE: hw/rtl/dqds_cfg_regs.sv
// Configuration register file for the input qualifier
`timescale 1ns / 1ps

module dqds_cfg_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wen,
	input  logic [dqds_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [dqds_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	output dqds_pkg::cfg_t                       cfg
);

	dqds_pkg::cfg_t cfg_q;

	// write the addressed register, ignore indexes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable_mask   <= dqds_pkg::ENABLE_RST;
			cfg_q.polarity_mask <= dqds_pkg::POLARITY_RST;
			cfg_q.function_map  <= dqds_pkg::FNMAP_RST;
			cfg_q.demand_low    <= dqds_pkg::DEMAND_LOW_RST;
			cfg_q.demand_high   <= dqds_pkg::DEMAND_HIGH_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				dqds_pkg::REG_ENABLE_MASK: begin
					cfg_q.enable_mask <= cfg_wdata[dqds_pkg::STATUS_W-1:0];
				end
				dqds_pkg::REG_POLARITY_MASK: begin
					cfg_q.polarity_mask <= cfg_wdata[dqds_pkg::STATUS_W-1:0];
				end
				dqds_pkg::REG_FUNCTION_MAP: begin
					cfg_q.function_map <= cfg_wdata;
				end
				dqds_pkg::REG_DEMAND_LOW: begin
					cfg_q.demand_low <= cfg_wdata[dqds_pkg::TABLE_WORD_W-1:0];
				end
				dqds_pkg::REG_DEMAND_HIGH: begin
					cfg_q.demand_high <= cfg_wdata[dqds_pkg::TABLE_WORD_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: hw/rtl/dqds_qualify.sv
// Combinational qualification, function decode and demand table select
`timescale 1ns / 1ps

module dqds_qualify #(
	parameter int unsigned NUM_INPUTS = dqds_pkg::NUM_INPUTS_DEF
) (
	input  logic [dqds_pkg::STATUS_W-1:0] raw_status,
	input  dqds_pkg::cfg_t                cfg,
	output dqds_pkg::result_t             result
);

	localparam int unsigned SW = dqds_pkg::STATUS_W;
	localparam int unsigned FW = dqds_pkg::FN_W;
	localparam int unsigned DW = dqds_pkg::DEMAND_W;

	logic [SW-1:0]                     in_range;
	logic [SW-1:0]                     qual;
	logic [SW-1:0]                     is_cmd;
	logic [SW-1:0]                     is_dem;
	logic [FW-1:0]                     fn     [SW];
	logic [4:0]                        dem_rank [SW];
	logic [SW-1:0]                     below_mask [SW];
	logic                              motor;
	logic                              dir;
	logic [dqds_pkg::DEMAND_IDX_W-1:0] dem_idx;
	logic [DW-1:0]                     entry;

	// qualify each input and decode its function code
	always_comb begin
		for (int n = 0; n < SW; n++) begin
			in_range[n] = (n < NUM_INPUTS);
			fn[n]       = cfg.function_map[n*FW +: FW];
			qual[n]     = in_range[n] &
				(cfg.enable_mask[n] ? (raw_status[n] ^ cfg.polarity_mask[n])
				                    : cfg.polarity_mask[n]);
			is_cmd[n]   = in_range[n] && (fn[n] <= dqds_pkg::FN_LAST_COMMAND);
			is_dem[n]   = in_range[n] && (fn[n] >= dqds_pkg::FN_DEMAND_FIRST)
				&& (fn[n] <= dqds_pkg::FN_DEMAND_LAST);
		end
	end

	// rank each demand input by the number of demand inputs below it
	always_comb begin
		for (int n = 0; n < SW; n++) begin
			below_mask[n] = (SW'(1) << n) - SW'(1);
			dem_rank[n]   = 5'($countones(is_dem & below_mask[n]));
		end
	end

	// form the table index from the first three demand inputs
	always_comb begin
		dem_idx = '0;
		for (int n = 0; n < SW; n++) begin
			for (int k = 0; k < dqds_pkg::DEMAND_IDX_W; k++) begin
				if (is_dem[n] && (dem_rank[n] == 5'(k))) begin
					dem_idx[k] = dem_idx[k] | qual[n];
				end
			end
		end
	end

	// last matching input wins for motor enable and direction
	always_comb begin
		motor = 1'b1;
		dir   = 1'b0;
		for (int n = 0; n < SW; n++) begin
			if (in_range[n] && (fn[n] == dqds_pkg::FN_MOTOR_ENABLE)) begin
				motor = qual[n];
			end
			if (in_range[n] && (fn[n] == dqds_pkg::FN_DIRECTION)) begin
				dir = qual[n];
			end
		end
	end

	// pick the table entry and clamp it
	always_comb begin
		if (dem_idx[2]) begin
			entry = cfg.demand_high[dem_idx[1:0]*DW +: DW];
		end else begin
			entry = cfg.demand_low[dem_idx[1:0]*DW +: DW];
		end
		if (entry > dqds_pkg::DEMAND_MAX) begin
			entry = dqds_pkg::DEMAND_MAX;
		end
	end

	assign result.qualified_status   = qual;
	assign result.command_values     = qual & is_cmd;
	assign result.motor_enabled      = motor;
	assign result.direction_inverted = dir;
	assign result.demand_percent     = (|is_dem) ? entry : '0;

endmodule

FILE: hw/rtl/digital_input_qualifier_demand_select_unit.sv
// Top level: digital input qualifier with function decode and demand select
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-----------------------------------------
//  in      | in_valid  | in_stall  | raw_status
//  out     | out_valid | out_stall | qualified_status, command_values,
//          |           |           | motor_enabled, direction_inverted,
//          |           |           | demand_percent
//  cfg     | cfg_wen   | -         | cfg_index, cfg_wdata
//
// One item per clock when out_stall does not hold the pipe. Stages: input register,
// then the qualify and table-select logic into the result register.
// Reset clears both valid flags and loads the register defaults.
// in_stall rises only when both stages hold a transfer and out_stall is high.
`timescale 1ns / 1ps

module digital_input_qualifier_demand_select_unit #(
	parameter int unsigned NUM_INPUTS = dqds_pkg::NUM_INPUTS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [dqds_pkg::STATUS_W-1:0]        raw_status,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [dqds_pkg::STATUS_W-1:0]        qualified_status,
	output logic [dqds_pkg::STATUS_W-1:0]        command_values,
	output logic                                 motor_enabled,
	output logic                                 direction_inverted,
	output logic [dqds_pkg::DEMAND_W-1:0]        demand_percent,
	input  logic                                 cfg_wen,
	input  logic [dqds_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [dqds_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	dqds_pkg::cfg_t                cfg;
	dqds_pkg::result_t             result;
	dqds_pkg::result_t             result_s2;
	logic [dqds_pkg::STATUS_W-1:0] raw_s1;
	logic                          valid_s1;
	logic                          valid_s2;
	logic                          advance;

	dqds_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	dqds_qualify #(
		.NUM_INPUTS (NUM_INPUTS)
	) u_qualify (
		.raw_status (raw_s1),
		.cfg        (cfg),
		.result     (result)
	);

	// advance the pipe when the result stage is empty or being taken
	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;

	// hold the valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// capture the input transfer and the result
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			raw_s1 <= raw_status;
		end
		if (advance && valid_s1) begin
			result_s2 <= result;
		end
	end

	assign out_valid          = valid_s2;
	assign qualified_status   = result_s2.qualified_status;
	assign command_values     = result_s2.command_values;
	assign motor_enabled      = result_s2.motor_enabled;
	assign direction_inverted = result_s2.direction_inverted;
	assign demand_percent     = result_s2.demand_percent;

endmodule

FILE: dv/dqds_qualifier_checker.sv
// Checker: tracks the register file, predicts each poll result and compares results
`timescale 1ns / 1ps

module dqds_qualifier_checker #(
	parameter int unsigned NUM_INPUTS = dqds_pkg::NUM_INPUTS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic                                 in_stall,
	input  logic [dqds_pkg::STATUS_W-1:0]        raw_status,
	input  logic                                 out_valid,
	input  logic                                 out_stall,
	input  logic [dqds_pkg::STATUS_W-1:0]        qualified_status,
	input  logic [dqds_pkg::STATUS_W-1:0]        command_values,
	input  logic                                 motor_enabled,
	input  logic                                 direction_inverted,
	input  logic [dqds_pkg::DEMAND_W-1:0]        demand_percent,
	input  logic                                 cfg_wen,
	input  logic [dqds_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [dqds_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	output int unsigned                          fail_count,
	output int unsigned                          outstanding
);

	// shadow copy of the register file
	logic [dqds_pkg::STATUS_W-1:0]     en_mask;
	logic [dqds_pkg::STATUS_W-1:0]     pol_mask;
	logic [dqds_pkg::CFG_DATA_W-1:0]   fn_map;
	logic [dqds_pkg::TABLE_WORD_W-1:0] dem_low;
	logic [dqds_pkg::TABLE_WORD_W-1:0] dem_high;

	dqds_pkg::result_t pending_results[$];
	dqds_pkg::result_t want;

	// print one line per mismatch and count it
	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] exp_val);
		$display("[%0t ns] mismatch on %s: got 0x%0h, expected 0x%0h",
			$time, what, got, exp_val);
		fail_count++;
	endtask

	// qualify one raw word against the shadow registers
	function automatic dqds_pkg::result_t qualify_sample(
			input logic [dqds_pkg::STATUS_W-1:0] raw);
		dqds_pkg::result_t                 r;
		logic                              b;
		logic [dqds_pkg::FN_W-1:0]         code;
		int unsigned                       n_demand;
		logic [dqds_pkg::DEMAND_IDX_W-1:0] sel;
		int unsigned                       pos;
		logic [dqds_pkg::DEMAND_W-1:0]     entry;
		r = '0;
		r.motor_enabled = 1'b1;
		n_demand = 0;
		sel = '0;
		for (int n = 0; n < NUM_INPUTS && n < dqds_pkg::STATUS_W; n++) begin
			b = en_mask[n] ? (raw[n] ^ pol_mask[n]) : pol_mask[n];
			code = fn_map[n*dqds_pkg::FN_W +: dqds_pkg::FN_W];
			r.qualified_status[n] = b;
			if (code <= dqds_pkg::FN_LAST_COMMAND)
				r.command_values[n] = b;
			if (code == dqds_pkg::FN_MOTOR_ENABLE)
				r.motor_enabled = b;
			if (code == dqds_pkg::FN_DIRECTION)
				r.direction_inverted = b;
			// only the first three demand inputs form the table index
			if (code >= dqds_pkg::FN_DEMAND_FIRST && code <= dqds_pkg::FN_DEMAND_LAST
					&& n_demand < 3) begin
				sel[n_demand] = b;
				n_demand++;
			end
		end
		if (n_demand != 0) begin
			pos = sel[1:0] * dqds_pkg::DEMAND_W;
			entry = sel[2] ? dem_high[pos +: dqds_pkg::DEMAND_W]
			               : dem_low[pos +: dqds_pkg::DEMAND_W];
			r.demand_percent = (entry > dqds_pkg::DEMAND_MAX) ? dqds_pkg::DEMAND_MAX : entry;
		end
		return r;
	endfunction

	// follow register writes, queue predictions, compare results
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_mask = dqds_pkg::ENABLE_RST;
			pol_mask = dqds_pkg::POLARITY_RST;
			fn_map = dqds_pkg::FNMAP_RST;
			dem_low = dqds_pkg::DEMAND_LOW_RST;
			dem_high = dqds_pkg::DEMAND_HIGH_RST;
			pending_results.delete();
			fail_count = 0;
			outstanding <= 0;
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					dqds_pkg::REG_ENABLE_MASK:
						en_mask = cfg_wdata[dqds_pkg::STATUS_W-1:0];
					dqds_pkg::REG_POLARITY_MASK:
						pol_mask = cfg_wdata[dqds_pkg::STATUS_W-1:0];
					dqds_pkg::REG_FUNCTION_MAP:
						fn_map = cfg_wdata;
					dqds_pkg::REG_DEMAND_LOW:
						dem_low = cfg_wdata[dqds_pkg::TABLE_WORD_W-1:0];
					dqds_pkg::REG_DEMAND_HIGH:
						dem_high = cfg_wdata[dqds_pkg::TABLE_WORD_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				pending_results.push_back(qualify_sample(raw_status));
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected result", qualified_status, 0);
				end else begin
					want = pending_results.pop_front();
					if (qualified_status !== want.qualified_status)
						report_mismatch("qualified_status", qualified_status,
							want.qualified_status);
					if (command_values !== want.command_values)
						report_mismatch("command_values", command_values,
							want.command_values);
					if (motor_enabled !== want.motor_enabled)
						report_mismatch("motor_enabled", motor_enabled, want.motor_enabled);
					if (direction_inverted !== want.direction_inverted)
						report_mismatch("direction_inverted", direction_inverted,
							want.direction_inverted);
					if (demand_percent !== want.demand_percent)
						report_mismatch("demand_percent", demand_percent,
							want.demand_percent);
				end
			end
			outstanding <= pending_results.size();
		end
	end

endmodule

FILE: dv/tb_digital_input_qualifier_demand_select_unit.sv
// Testbench top: drives directed and random polls and register settings, gives the verdict
`timescale 1ns / 1ps

module tb_digital_input_qualifier_demand_select_unit;

	localparam int unsigned CLK_HALF      = 6;
	localparam int unsigned RESET_CYCLES  = 5;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned HOLD_CYCLES   = 200;
	localparam int unsigned LIMIT_CYCLES  = 200000;
	localparam int unsigned RAND_PHASES   = 16;
	localparam int unsigned PHASE_ITEMS   = 80;

	localparam int unsigned SW  = dqds_pkg::STATUS_W;
	localparam int unsigned DW  = dqds_pkg::DEMAND_W;
	localparam int unsigned FW  = dqds_pkg::FN_W;
	localparam int unsigned CW  = dqds_pkg::CFG_DATA_W;
	localparam int unsigned IW  = dqds_pkg::CFG_INDEX_W;
	localparam int unsigned TW  = dqds_pkg::TABLE_WORD_W;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [SW-1:0]          raw_status = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [SW-1:0]          qualified_status;
	logic [SW-1:0]          command_values;
	logic                   motor_enabled;
	logic                   direction_inverted;
	logic [DW-1:0]          demand_percent;
	logic                   cfg_wen = 1'b0;
	logic [IW-1:0]          cfg_index = '0;
	logic [CW-1:0]          cfg_wdata = '0;

	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned cycle_count;
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned hold_left = 0;
	logic        hold_req = 1'b0;

	digital_input_qualifier_demand_select_unit uut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.raw_status         (raw_status),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.qualified_status   (qualified_status),
		.command_values     (command_values),
		.motor_enabled      (motor_enabled),
		.direction_inverted (direction_inverted),
		.demand_percent     (demand_percent),
		.cfg_wen            (cfg_wen),
		.cfg_index          (cfg_index),
		.cfg_wdata          (cfg_wdata)
	);

	dqds_qualifier_checker u_checker (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.raw_status         (raw_status),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.qualified_status   (qualified_status),
		.command_values     (command_values),
		.motor_enabled      (motor_enabled),
		.direction_inverted (direction_inverted),
		.demand_percent     (demand_percent),
		.cfg_wen            (cfg_wen),
		.cfg_index          (cfg_index),
		.cfg_wdata          (cfg_wdata),
		.fail_count         (mismatches),
		.outstanding        (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// result side: random stall, or a long hold-off once requested
	always @(posedge clk) begin
		if (hold_req)
			hold_left = HOLD_CYCLES;
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// give up after a generous number of cycles
	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_digital_input_qualifier_demand_select_unit: done, errors");
		$finish;
	end

	// fill the bits above a register's width with noise
	function automatic logic [CW-1:0] with_noise(input logic [CW-1:0] data,
			input int unsigned w);
		logic [CW-1:0] keep;
		keep = (w >= CW) ? '1 : ((64'd1 << w) - 64'd1);
		return ({$urandom, $urandom} & ~keep) | (data & keep);
	endfunction

	function automatic logic [CW-1:0] pack_table(input logic [DW-1:0] e0, e1,
			e2, e3);
		return {8'h00, e3, e2, e1, e0};
	endfunction

	// mostly in range, sometimes above the clamp
	function automatic logic [DW-1:0] random_entry();
		if ($urandom_range(5) == 0)
			return DW'($urandom_range(dqds_pkg::DEMAND_MAX + 1, (1 << DW) - 1));
		return DW'($urandom_range(dqds_pkg::DEMAND_MAX));
	endfunction

	function automatic logic [SW-1:0] random_mask();
		case ($urandom_range(3))
			0: return '1;
			1: return '0;
			default: return SW'($urandom);
		endcase
	endfunction

	// mostly live function codes, some unused ones
	function automatic logic [CW-1:0] random_fn_map();
		logic [CW-1:0] m;
		if ($urandom_range(7) == 0)
			return {$urandom, $urandom};
		for (int n = 0; n < SW; n++)
			m[n*FW +: FW] = ($urandom_range(4) == 0) ?
				FW'($urandom_range(dqds_pkg::FN_DEMAND_LAST + 1, 15)) :
				FW'($urandom_range(dqds_pkg::FN_DEMAND_LAST));
		return m;
	endfunction

	function automatic logic [SW-1:0] random_raw();
		if ($urandom_range(3) == 0)
			return SW'(1) << $urandom_range(SW - 1);
		return SW'($urandom);
	endfunction

	// present one register write; the caller lowers the enable
	task automatic write_reg(input logic [IW-1:0] idx,
			input logic [CW-1:0] data);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	// load all registers, then a stray write past the last index
	task automatic apply_settings(input logic [SW-1:0] en, pol,
			input logic [CW-1:0] fmap, dlow, dhigh);
		write_reg(dqds_pkg::REG_ENABLE_MASK, with_noise(en, SW));
		write_reg(dqds_pkg::REG_POLARITY_MASK, with_noise(pol, SW));
		write_reg(dqds_pkg::REG_FUNCTION_MAP, fmap);
		write_reg(dqds_pkg::REG_DEMAND_LOW, with_noise(dlow, TW));
		write_reg(dqds_pkg::REG_DEMAND_HIGH, with_noise(dhigh, TW));
		write_reg(dqds_pkg::REG_DEMAND_HIGH + IW'($urandom_range(1, 3)),
			{$urandom, $urandom});
		cfg_wen <= 1'b0;
	endtask

	// offer one poll and hold it until the transfer
	task automatic send_poll(input logic [SW-1:0] raw);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		raw_status <= raw;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// drop valid and wait until every prediction has been matched
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// 0: no idling, 1: sender idle, 2: receiver stalls, 3: both lightly
	task automatic set_idling(input int unsigned mode);
		case (mode)
			1: begin send_idle_pct = 83; stall_pct <= 0; end
			2: begin send_idle_pct = 0; stall_pct <= 83; end
			3: begin send_idle_pct = 9; stall_pct <= 9; end
			default: begin send_idle_pct = 0; stall_pct <= 0; end
		endcase
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: three demand inputs, direction on input 0, no motor enable
		set_idling(0);
		send_poll(16'h0000);
		send_poll(16'hFFFF);
		send_poll(16'h0002);
		send_poll(16'h0004);
		send_poll(16'h0008);
		send_poll(16'h000E);
		send_poll(16'h0001);
		settle();

		// all inputs disabled and inverted, all motor enable, no demand, full tables
		apply_settings(16'h0000, 16'hFFFF, 64'h0, '1, '1);
		send_poll(16'hFFFF);
		send_poll(16'h0000);
		settle();

		// function codes 0 to 13, a fourth demand input, clamped entries
		apply_settings(16'hFFFF, 16'h0000, 64'h02DC_BA98_7654_3210,
			pack_table(14'd1, 14'd10000, 14'd10001, 14'd16383),
			pack_table(14'd2, 14'd12345, 14'd0, 14'd9999));
		send_poll(16'h0000);
		send_poll(16'hFFFF);
		send_poll(16'h0020);
		send_poll(16'h0040);
		send_poll(16'h0080);
		send_poll(16'h00C0);
		send_poll(16'h0100);
		send_poll(16'h8000);
		send_poll(16'h4004);
		send_poll(16'h0001);
		settle();

		// single demand input on the top bit, mixed enable and polarity
		apply_settings(16'hF0F0, 16'h00FF, 64'h8FFF_FFFF_FFFF_FFF0,
			pack_table(14'd0, 14'd16383, 14'd7, 14'd8),
			pack_table(14'd3, 14'd4, 14'd5, 14'd6));
		send_poll(16'hFFFF);
		send_poll(16'h0000);
		send_poll(16'h5A5A);
		settle();

		// random phases, the first two at the register extremes
		for (int p = 0; p < RAND_PHASES; p++) begin
			if (p == 0)
				apply_settings('0, '0, '0, '0, '0);
			else if (p == 1)
				apply_settings('1, '1, '1, '1, '1);
			else
				apply_settings(random_mask(), random_mask(), random_fn_map(),
					pack_table(random_entry(), random_entry(), random_entry(),
						random_entry()),
					pack_table(random_entry(), random_entry(), random_entry(),
						random_entry()));
			set_idling(p % 4);
			// hold the result side off so the block backs up
			if (p == 3 || p == 10) begin
				hold_req <= 1'b1;
				@(posedge clk);
				hold_req <= 1'b0;
			end
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_poll(random_raw());
			settle();
		end

		if (mismatches == 0)
			$display("tb_digital_input_qualifier_demand_select_unit: done, clean");
		else
			$display("tb_digital_input_qualifier_demand_select_unit: done, errors");
		$finish;
	end

endmodule

FILE: digital_input_qualifier_demand_select_unit.f
hw/rtl/dqds_pkg.sv
hw/rtl/dqds_cfg_regs.sv
hw/rtl/dqds_qualify.sv
hw/rtl/digital_input_qualifier_demand_select_unit.sv
dv/dqds_qualifier_checker.sv
dv/tb_digital_input_qualifier_demand_select_unit.sv
